@@ rtl/fxq_pkg.sv @@
// Shared types and operation codes for the Q24.8 fixed-point ALU.
package fxq_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_I2F  = 4'd8,
        OP_F2I  = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] a_raw;
        logic signed [31:0] b_raw;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
        logic               div_overflow;
    } t_rsp;

    // Classified request as it sits in the queue
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        mag_a;
        logic [31:0]        mag_b;
        logic               neg;
        logic               dz;
        logic [31:0]        res;
        logic               less;
        logic               equal;
        logic               greater;
    } t_job;

    // Control carried alongside the back-end pipeline
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic        dz;
        logic [31:0] res;
        logic        less;
        logic        equal;
        logic        greater;
    } t_ctl;

endpackage

@@ rtl/fxq_front.sv @@
// Front end: decode a request, compute the simple operations and flags.
module fxq_front
    import fxq_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  t_req i_req,
    output t_job o_job
);

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;

    assign a  = i_req.a_raw;
    assign b  = i_req.b_raw;
    assign lt = (a < b);

    // Classify and evaluate the simple operations
    always_comb begin
        o_job         = '0;
        o_job.kind    = K_SIMPLE;
        o_job.a       = a;
        o_job.b       = b;
        o_job.mag_a   = a[31] ? 32'(-a) : 32'(a);
        o_job.mag_b   = b[31] ? 32'(-b) : 32'(b);
        o_job.neg     = a[31] ^ b[31];
        o_job.less    = lt;
        o_job.equal   = (a == b);
        o_job.greater = (a > b);
        unique case (i_req.req_type)
            OP_ADD: o_job.res = 32'(a + b);
            OP_SUB: o_job.res = 32'(a - b);
            OP_MUL: o_job.kind = K_MUL;
            OP_DIV: begin
                o_job.kind = K_DIV;
                o_job.dz   = (b == 32'sd0);
            end
            OP_MIN: o_job.res = lt ? a : b;
            OP_MAX: o_job.res = lt ? b : a;
            OP_INC: o_job.res = 32'(a + 32'sd1);
            OP_DEC: o_job.res = 32'(a - 32'sd1);
            OP_I2F: o_job.res = a << FRAC_BITS;
            OP_F2I: o_job.res = a >>> FRAC_BITS;
            default: o_job.res = '0;
        endcase
    end

endmodule

@@ rtl/fxq_fifo.sv @@
// Short request queue between front and back ends.
module fxq_fifo
    import fxq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int Depth = 4;

    t_job       r_mem [Depth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'(Depth));
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

@@ rtl/fxq_back.sv @@
// Back end: pipelined multiplier and one-bit-per-stage divider with rounding.
module fxq_back
    import fxq_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_valid,
    output t_rsp o_rsp
);

    // Quotient width: magnitude, fraction bits and one rounding bit
    localparam int W = 33 + FRAC_BITS;

    logic               r_vld  [W+1];
    t_ctl               r_ctl  [W+1];
    logic [W-1:0]       r_nq   [W+1];
    logic [31:0]        r_rem  [W+1];
    logic [31:0]        r_mb   [W+1];
    logic signed [63:0] r_prod;

    // Load the first stage from the queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= '{kind: i_job.kind, neg: i_job.neg, dz: i_job.dz, res: i_job.res,
                          less: i_job.less, equal: i_job.equal, greater: i_job.greater};
            r_prod   <= 64'(i_job.a) * 64'(i_job.b);
            r_nq[0]  <= {i_job.mag_a, {(FRAC_BITS + 1){1'b0}}};
            r_rem[0] <= '0;
            r_mb[0]  <= i_job.mag_b;
        end
    end

    // One restoring divide step per stage; the product is scaled in stage one
    for (genvar k = 1; k <= W; k++) begin : g_stage
        logic [32:0]        trial;
        logic [32:0]        diff;
        logic               ge;
        logic signed [63:0] scaled;
        t_ctl               ctl;

        assign trial  = {r_rem[k-1], r_nq[k-1][W-1]};
        assign diff   = trial - {1'b0, r_mb[k-1]};
        assign ge     = (trial >= {1'b0, r_mb[k-1]});
        assign scaled = r_prod[63]
                      ? ((r_prod + ((64'sd1 <<< FRAC_BITS) - 64'sd1)) >>> FRAC_BITS)
                      : (r_prod >>> FRAC_BITS);

        always_comb begin
            ctl = r_ctl[k-1];
            if (k == 1 && ctl.kind == K_MUL) ctl.res = scaled[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k] <= ctl;
                r_rem[k] <= ge ? diff[31:0] : trial[31:0];
                r_nq[k]  <= {r_nq[k-1][W-2:0], ge};
                r_mb[k]  <= r_mb[k-1];
            end
        end
    end

    // Round half away, saturate and sign the quotient
    logic [W-1:0] q_rnd;
    logic         ovf;
    t_rsp         n_rsp;
    t_rsp         r_rsp;
    logic         r_out_vld;

    assign q_rnd = (r_nq[W] + W'(1)) >> 1;

    always_comb begin
        ovf = r_ctl[W].neg ? (q_rnd > (W'(1) << 31)) : (q_rnd > W'(32'h7FFF_FFFF));
        n_rsp.result_raw     = r_ctl[W].res;
        n_rsp.a_less         = r_ctl[W].less;
        n_rsp.a_equal        = r_ctl[W].equal;
        n_rsp.a_greater      = r_ctl[W].greater;
        n_rsp.divide_by_zero = 1'b0;
        n_rsp.div_overflow   = 1'b0;
        if (r_ctl[W].kind == K_DIV) begin
            if (r_ctl[W].dz) begin
                n_rsp.divide_by_zero = 1'b1;
                n_rsp.result_raw     = '0;
            end else if (ovf) begin
                n_rsp.div_overflow = 1'b1;
                n_rsp.result_raw   = r_ctl[W].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_rsp.result_raw = r_ctl[W].neg ? 32'(-q_rnd[31:0]) : q_rnd[31:0];
            end
        end
    end

    // Hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_rsp <= n_rsp;
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule

@@ rtl/fixed_point_q24_8_alu.sv @@
// Top level of the fixed-point ALU: front end, request queue and back end.
// A request passes through the queue, the back-end load stage, the divide stages and the output register.
// Throughput: one request per cycle while the output is not stalled; the divider retires one quotient bit per stage.
// A stalled output freezes the whole back-end pipeline; the 4-entry queue absorbs input.
// Reset is synchronous, active low, and empties the queue and all pipeline valids.
module fixed_point_q24_8_alu
    import fxq_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_job job_in, job_out;
    logic full, empty, en;

    fxq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_req (i_req),
        .o_job (job_in)
    );

    fxq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !full),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (en && !empty),
        .o_empty (empty),
        .o_data  (job_out)
    );

    // Advance the back end whenever the output slot is free or being taken
    assign en      = !o_valid || !i_stall;
    assign o_stall = full;

    fxq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (!empty),
        .i_job   (job_out),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_one_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_rsp.a_less, o_rsp.a_equal, o_rsp.a_greater}))
        else $error("compare flags not one-hot");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.divide_by_zero) |-> (o_rsp.result_raw == 32'sd0 && !o_rsp.div_overflow))
        else $error("divide by zero response malformed");
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.div_overflow) |->
            (o_rsp.result_raw == 32'sh7FFF_FFFF || o_rsp.result_raw == 32'sh8000_0000))
        else $error("overflow not saturated");
`endif

endmodule
